// ===== rtl/core/servo_angle_pwm_generator_assert.svh =====
// assertion macros shared by the servo pwm checker
`ifndef SERVO_ANGLE_PWM_GENERATOR_ASSERT_SVH
`define SERVO_ANGLE_PWM_GENERATOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SPWM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define SPWM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/servo_pwm_pkg.sv =====
// types and constants of the servo pwm generator
`default_nettype none

package servo_pwm_pkg;

    // width of angles, pulse widths, periods and compare values
    localparam int VAL_W = 16;

    // default width of the period counter
    localparam int COUNT_BITS_DEF = 16;

    // configuration register indexes
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_MIN_ANGLE    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MAX_ANGLE    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_MIN_PULSE_US = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_MAX_PULSE_US = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PERIOD_US    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_PERIOD_TOP   = 3'd5;

    // configuration reset values
    localparam logic signed [VAL_W-1:0] MIN_ANGLE_RST    = 16'sd0;
    localparam logic signed [VAL_W-1:0] MAX_ANGLE_RST    = 16'sd180;
    localparam logic        [VAL_W-1:0] MIN_PULSE_US_RST = 16'd544;
    localparam logic        [VAL_W-1:0] MAX_PULSE_US_RST = 16'd2400;
    localparam logic        [VAL_W-1:0] PERIOD_US_RST    = 16'd20000;
    localparam logic        [VAL_W-1:0] PERIOD_TOP_RST   = 16'd64615;

    // held angle while output is off
    localparam logic signed [VAL_W-1:0] ANGLE_OFF = -16'sd1;

    // item opcodes
    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_SET    = 2'd1,
        OP_DETACH = 2'd2
    } op_t;

endpackage

`default_nettype wire

// ===== rtl/core/servo_angle_pwm_generator.sv =====
// servo pin pwm generator with a digit-serial angle-to-compare converter
// tick, detach and unused-opcode items give their result in the cycle after acceptance
// a set-angle item goes through setup, the shared shift-add multiplier (1 bit per cycle),
//   the shared restoring divider (1 bit per cycle), both again, then a finish state
// throughput: one tick item per cycle while results are taken; a set-angle item blocks new items until it commits
// reset (async, active low): registers to defaults, counter 0, output off, pin low, angle -1
`default_nettype none

module servo_angle_pwm_generator #(
    parameter int COUNT_BITS = servo_pwm_pkg::COUNT_BITS_DEF
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    // configuration write port
    input  wire logic                                     cfg_we,
    input  wire logic [servo_pwm_pkg::REG_IDX_W-1:0]      cfg_index,
    input  wire logic [servo_pwm_pkg::VAL_W-1:0]          cfg_data,
    // input channel
    input  wire logic                                     in_valid,
    output      logic                                     in_stall,
    input  wire logic [1:0]                               opcode,
    input  wire logic signed [servo_pwm_pkg::VAL_W-1:0]   angle_value,
    // output channel
    output      logic                                     out_valid,
    input  wire logic                                     out_stall,
    output      logic                                     pin_level,
    output      logic signed [servo_pwm_pkg::VAL_W-1:0]   current_angle,
    output      logic [servo_pwm_pkg::VAL_W-1:0]          compare_value,
    output      logic                                     output_enabled
);
    import servo_pwm_pkg::*;

    // compare width covering both the counter and period_top
    localparam int CW = (COUNT_BITS > VAL_W) ? COUNT_BITS : VAL_W;
    // last step index of the serial multiplier and divider
    localparam logic [4:0] MUL_LAST = 5'(VAL_W - 1);
    localparam logic [4:0] DIV_LAST = 5'(2 * VAL_W - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_MUL1,
        S_DIV1,
        S_US,
        S_MUL2,
        S_DIV2,
        S_FINISH
    } state_t;

    // configuration registers
    logic signed [VAL_W-1:0] min_angle_reg;
    logic signed [VAL_W-1:0] max_angle_reg;
    logic [VAL_W-1:0]        min_pulse_us_reg;
    logic [VAL_W-1:0]        max_pulse_us_reg;
    logic [VAL_W-1:0]        period_us_reg;
    logic [VAL_W-1:0]        period_top_reg;

    // control and architectural state
    state_t                  state_reg, state_next;
    logic [4:0]              cnt_reg, cnt_next;
    logic [COUNT_BITS-1:0]   tick_count_reg, tick_count_next;
    logic [VAL_W-1:0]        pulse_compare_reg, pulse_compare_next;
    logic signed [VAL_W-1:0] held_angle_reg, held_angle_next;
    logic                    pin_reg, pin_next;
    logic                    enabled_reg, enabled_next;
    logic                    out_valid_reg, out_valid_next;

    // serial datapath
    logic signed [VAL_W-1:0] clamp_reg, clamp_next;
    logic [2*VAL_W-1:0]      shift_reg, shift_next;
    logic [VAL_W-1:0]        rem_reg, rem_next;
    logic [VAL_W-1:0]        mcand_reg, mcand_next;
    logic [VAL_W-1:0]        dr_mag_reg, dr_mag_next;
    logic                    neg_reg, neg_next;
    logic                    range_eq_reg, range_eq_next;

    logic                    in_acc;
    logic                    out_busy;

    // tick arithmetic
    logic [COUNT_BITS-1:0]   tick_adv;
    logic                    match_cmp;
    logic                    match_top;

    // clamp and range differences
    logic signed [VAL_W-1:0] angle_clamped;
    logic [VAL_W:0]          da, da_neg, dp, dp_neg, dr, dr_neg;

    // one multiplier step
    logic [VAL_W:0]          mul_sum;
    logic [2*VAL_W-1:0]      mul_shift;

    // one divider step
    logic [VAL_W-1:0]        divisor;
    logic [VAL_W+1:0]        div_diff;
    logic                    div_ge;
    logic [VAL_W-1:0]        div_rem;
    logic [2*VAL_W-1:0]      div_shift;

    // pulse width and final compare value
    logic [VAL_W-1:0]        q_lo, q_signed, pulse_us;
    logic [VAL_W-1:0]        cmp_val;

    assign out_busy  = out_valid_reg && out_stall;
    assign in_stall  = (state_reg != S_IDLE) || out_busy;
    assign in_acc    = in_valid && !in_stall;

    // the state registers are the result item; it is held while the item waits
    assign out_valid      = out_valid_reg;
    assign pin_level      = pin_reg;
    assign current_angle  = held_angle_reg;
    assign compare_value  = pulse_compare_reg;
    assign output_enabled = enabled_reg;

    // counter advance: back to zero at or past the top, else count up (wraps at COUNT_BITS)
    always_comb
    begin
        if (CW'(tick_count_reg) >= CW'(period_top_reg))
        begin
            tick_adv = '0;
        end
        else
        begin
            tick_adv = tick_count_reg + COUNT_BITS'(1);
        end
        match_cmp = (CW'(tick_adv) == CW'(pulse_compare_reg));
        match_top = (CW'(tick_adv) == CW'(period_top_reg));
    end

    // clamp tests the floor first, so an inverted range still ends at a bound
    always_comb
    begin
        if (angle_value < min_angle_reg)
        begin
            angle_clamped = min_angle_reg;
        end
        else if (angle_value > max_angle_reg)
        begin
            angle_clamped = max_angle_reg;
        end
        else
        begin
            angle_clamped = angle_value;
        end
    end

    // signed differences of the first linear map, taken apart into sign and magnitude
    assign da     = {clamp_reg[VAL_W-1], clamp_reg} - {min_angle_reg[VAL_W-1], min_angle_reg};
    assign dp     = {1'b0, max_pulse_us_reg} - {1'b0, min_pulse_us_reg};
    assign dr     = {max_angle_reg[VAL_W-1], max_angle_reg}
                  - {min_angle_reg[VAL_W-1], min_angle_reg};
    assign da_neg = ~da + (VAL_W+1)'(1);
    assign dp_neg = ~dp + (VAL_W+1)'(1);
    assign dr_neg = ~dr + (VAL_W+1)'(1);

    // shift-add multiplier: add the multiplicand on a set low bit, shift right
    assign mul_sum   = {1'b0, shift_reg[2*VAL_W-1:VAL_W]}
                     + (shift_reg[0] ? {1'b0, mcand_reg} : '0);
    assign mul_shift = {mul_sum, shift_reg[VAL_W-1:1]};

    // restoring divider: dividend shifts out the top, quotient bits shift in below
    assign divisor   = (state_reg == S_DIV1) ? dr_mag_reg : period_us_reg;
    assign div_diff  = {1'b0, rem_reg, shift_reg[2*VAL_W-1]} - {2'b00, divisor};
    assign div_ge    = !div_diff[VAL_W+1];
    assign div_rem   = div_ge ? div_diff[VAL_W-1:0] : {rem_reg[VAL_W-2:0], shift_reg[2*VAL_W-1]};
    assign div_shift = {shift_reg[2*VAL_W-2:0], div_ge};

    // pulse width: quotient takes the sign of product over range,
    // equal range gives the minimum pulse
    assign q_lo     = shift_reg[VAL_W-1:0];
    assign q_signed = neg_reg ? (~q_lo + VAL_W'(1)) : q_lo;
    assign pulse_us = range_eq_reg ? min_pulse_us_reg : (min_pulse_us_reg + q_signed);

    // zero period gives a zero compare value
    assign cmp_val  = (period_us_reg == '0) ? '0 : shift_reg[VAL_W-1:0];

    always_comb
    begin
        state_next         = state_reg;
        cnt_next           = cnt_reg;
        tick_count_next    = tick_count_reg;
        pulse_compare_next = pulse_compare_reg;
        held_angle_next    = held_angle_reg;
        pin_next           = pin_reg;
        enabled_next       = enabled_reg;
        out_valid_next     = out_busy;

        clamp_next    = clamp_reg;
        shift_next    = shift_reg;
        rem_next      = rem_reg;
        mcand_next    = mcand_reg;
        dr_mag_next   = dr_mag_reg;
        neg_next      = neg_reg;
        range_eq_next = range_eq_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    case (opcode)
                        OP_TICK:
                        begin
                            tick_count_next = tick_adv;
                            if (enabled_reg)
                            begin
                                // period end wins over pulse end on the same tick
                                if (match_top)
                                begin
                                    pin_next = 1'b1;
                                end
                                else if (match_cmp)
                                begin
                                    pin_next = 1'b0;
                                end
                            end
                            out_valid_next = 1'b1;
                        end
                        OP_SET:
                        begin
                            clamp_next = angle_clamped;
                            state_next = S_SETUP;
                        end
                        OP_DETACH:
                        begin
                            pulse_compare_next = '0;
                            enabled_next       = 1'b0;
                            pin_next           = 1'b0;
                            held_angle_next    = ANGLE_OFF;
                            out_valid_next     = 1'b1;
                        end
                        default:
                        begin
                            // unused opcode only reports the current state
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            S_SETUP:
            begin
                // |angle - floor| * |pulse span|, sign of the whole quotient kept aside
                mcand_next    = dp[VAL_W] ? dp_neg[VAL_W-1:0] : dp[VAL_W-1:0];
                shift_next    = {{VAL_W{1'b0}}, (da[VAL_W] ? da_neg[VAL_W-1:0] : da[VAL_W-1:0])};
                dr_mag_next   = dr[VAL_W] ? dr_neg[VAL_W-1:0] : dr[VAL_W-1:0];
                neg_next      = da[VAL_W] ^ dp[VAL_W] ^ dr[VAL_W];
                range_eq_next = (max_angle_reg == min_angle_reg);
                cnt_next      = '0;
                state_next    = S_MUL1;
            end
            S_MUL1, S_MUL2:
            begin
                shift_next = mul_shift;
                cnt_next   = cnt_reg + 5'd1;
                if (cnt_reg == MUL_LAST)
                begin
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = (state_reg == S_MUL1) ? S_DIV1 : S_DIV2;
                end
            end
            S_DIV1:
            begin
                shift_next = div_shift;
                rem_next   = div_rem;
                cnt_next   = cnt_reg + 5'd1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = S_US;
                end
            end
            S_US:
            begin
                // pulse width times period_top
                mcand_next = period_top_reg;
                shift_next = {{VAL_W{1'b0}}, pulse_us};
                cnt_next   = '0;
                state_next = S_MUL2;
            end
            S_DIV2:
            begin
                shift_next = div_shift;
                rem_next   = div_rem;
                cnt_next   = cnt_reg + 5'd1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                // commit only once the previous item has left the output
                if (!out_busy)
                begin
                    if (cmp_val != '0)
                    begin
                        pulse_compare_next = cmp_val;
                        enabled_next       = 1'b1;
                        held_angle_next    = clamp_reg;
                    end
                    else
                    begin
                        pulse_compare_next = '0;
                        enabled_next       = 1'b0;
                        pin_next           = 1'b0;
                        held_angle_next    = ANGLE_OFF;
                    end
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_angle_reg    <= MIN_ANGLE_RST;
            max_angle_reg    <= MAX_ANGLE_RST;
            min_pulse_us_reg <= MIN_PULSE_US_RST;
            max_pulse_us_reg <= MAX_PULSE_US_RST;
            period_us_reg    <= PERIOD_US_RST;
            period_top_reg   <= PERIOD_TOP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MIN_ANGLE:    min_angle_reg    <= cfg_data;
                REG_MAX_ANGLE:    max_angle_reg    <= cfg_data;
                REG_MIN_PULSE_US: min_pulse_us_reg <= cfg_data;
                REG_MAX_PULSE_US: max_pulse_us_reg <= cfg_data;
                REG_PERIOD_US:    period_us_reg    <= cfg_data;
                REG_PERIOD_TOP:   period_top_reg   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // state machine, counter and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            cnt_reg           <= '0;
            tick_count_reg    <= '0;
            pulse_compare_reg <= '0;
            held_angle_reg    <= ANGLE_OFF;
            pin_reg           <= 1'b0;
            enabled_reg       <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            cnt_reg           <= cnt_next;
            tick_count_reg    <= tick_count_next;
            pulse_compare_reg <= pulse_compare_next;
            held_angle_reg    <= held_angle_next;
            pin_reg           <= pin_next;
            enabled_reg       <= enabled_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // serial datapath
    always_ff @(posedge clk)
    begin
        clamp_reg    <= clamp_next;
        shift_reg    <= shift_next;
        rem_reg      <= rem_next;
        mcand_reg    <= mcand_next;
        dr_mag_reg   <= dr_mag_next;
        neg_reg      <= neg_next;
        range_eq_reg <= range_eq_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/servo_pwm_chk.sv =====
// port-level assertion checker for the servo pwm generator, with its bind
`default_nettype none
`include "servo_angle_pwm_generator_assert.svh"

module servo_pwm_chk (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     in_valid,
    input  wire logic                                     in_stall,
    input  wire logic [1:0]                               opcode,
    input  wire logic                                     out_valid,
    input  wire logic                                     out_stall,
    input  wire logic                                     pin_level,
    input  wire logic signed [servo_pwm_pkg::VAL_W-1:0]   current_angle,
    input  wire logic [servo_pwm_pkg::VAL_W-1:0]          compare_value,
    input  wire logic                                     output_enabled
);
    import servo_pwm_pkg::*;

    // output off always shows zero compare, angle -1 and a low pin
    `SPWM_ASSERT_NOW(a_off_state, !output_enabled,
        (compare_value == '0) && (current_angle == ANGLE_OFF) && !pin_level,
        "disabled output with stale compare, angle or pin")

    // output on always has a nonzero compare value
    `SPWM_ASSERT_NOW(a_on_cmp, output_enabled, compare_value != '0,
        "enabled output with zero compare value")

    // an accepted detach item turns the output off
    `SPWM_ASSERT_NEXT(a_detach_off, in_valid && !in_stall && (opcode == OP_DETACH),
        !output_enabled, "output still enabled after detach")

    // a stalled result item stays offered
    `SPWM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid,
        "result item dropped while stalled")

endmodule

bind servo_angle_pwm_generator servo_pwm_chk u_servo_pwm_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .opcode         (opcode),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .pin_level      (pin_level),
    .current_angle  (current_angle),
    .compare_value  (compare_value),
    .output_enabled (output_enabled)
);

`default_nettype wire

// ===== verif/servo_pwm_checker.sv =====
// checker for the servo pwm generator: predicts every item's result and compares it
`default_nettype none

module servo_pwm_checker
    import servo_pwm_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [REG_IDX_W-1:0] cfg_index,
    input  wire logic [VAL_W-1:0]     cfg_data,
    input  wire logic                 in_valid,
    input  wire logic                 in_stall,
    input  wire logic [1:0]           opcode,
    input  wire logic [VAL_W-1:0]     angle_value,
    input  wire logic                 out_valid,
    input  wire logic                 out_stall,
    input  wire logic                 pin_level,
    input  wire logic [VAL_W-1:0]     current_angle,
    input  wire logic [VAL_W-1:0]     compare_value,
    input  wire logic                 output_enabled,
    output int                        fail_count,
    output int                        outstanding
);

    localparam int PRINT_MAX = 40;

    typedef struct packed {
        logic             pin;
        logic [VAL_W-1:0] angle;
        logic [VAL_W-1:0] compare;
        logic             enabled;
    } servo_out_t;

    // settings as last written
    logic [VAL_W-1:0] lo_angle, hi_angle, pulse_lo, pulse_hi, period_len, period_end;

    // generator state
    logic [COUNT_BITS-1:0] period_count;
    logic [VAL_W-1:0]      pulse_end;
    logic [VAL_W-1:0]      held_angle;
    logic                  pin_q;
    logic                  enabled_q;

    servo_out_t due_outputs[$];

    initial fail_count = 0;

    function automatic void shut_output();
        pulse_end  = '0;
        enabled_q  = 1'b0;
        pin_q      = 1'b0;
        held_angle = ANGLE_OFF;
    endfunction

    function automatic servo_out_t advance_servo(input logic [1:0] op,
                                                 input logic [VAL_W-1:0] req);
        longint lo, hi, a, us, cmp;
        servo_out_t res;
        case (op)
            OP_TICK:
            begin
                if (period_count >= period_end)
                    period_count = '0;
                else
                    period_count = period_count + COUNT_BITS'(1);
                if (enabled_q)
                begin
                    // pulse end first, so a shared count leaves the pin high
                    if (period_count == pulse_end)
                        pin_q = 1'b0;
                    if (period_count == period_end)
                        pin_q = 1'b1;
                end
            end
            OP_SET:
            begin
                lo = longint'($signed(lo_angle));
                hi = longint'($signed(hi_angle));
                a  = longint'($signed(req));
                // floor tested first, matters for an inverted range
                if (a < lo)
                    a = lo;
                else if (a > hi)
                    a = hi;
                held_angle = a[VAL_W-1:0];
                if (hi == lo)
                    us = longint'(pulse_lo);
                else
                    us = ((a - lo) * (longint'(pulse_hi) - longint'(pulse_lo))) / (hi - lo)
                         + longint'(pulse_lo);
                us = longint'(us[VAL_W-1:0]);
                if (period_len == '0)
                    cmp = 0;
                else
                    cmp = (us * longint'(period_end)) / longint'(period_len);
                pulse_end = cmp[VAL_W-1:0];
                if (pulse_end != '0)
                    enabled_q = 1'b1;
                else
                    shut_output();
            end
            OP_DETACH:
                shut_output();
            default:
                ;
        endcase
        res.pin     = pin_q;
        res.angle   = held_angle;
        res.compare = pulse_end;
        res.enabled = enabled_q;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                   input logic [VAL_W-1:0] want);
        fail_count++;
        if (fail_count <= PRINT_MAX)
            $display("%0t: %s mismatch, got %h want %h", $time, what, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        servo_out_t want;
        if (!rst_n)
        begin
            lo_angle     = MIN_ANGLE_RST;
            hi_angle     = MAX_ANGLE_RST;
            pulse_lo     = MIN_PULSE_US_RST;
            pulse_hi     = MAX_PULSE_US_RST;
            period_len   = PERIOD_US_RST;
            period_end   = PERIOD_TOP_RST;
            period_count = '0;
            shut_output();
            due_outputs.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MIN_ANGLE:    lo_angle   = cfg_data;
                    REG_MAX_ANGLE:    hi_angle   = cfg_data;
                    REG_MIN_PULSE_US: pulse_lo   = cfg_data;
                    REG_MAX_PULSE_US: pulse_hi   = cfg_data;
                    REG_PERIOD_US:    period_len = cfg_data;
                    REG_PERIOD_TOP:   period_end = cfg_data;
                    default:          ;
                endcase
            end

            if (out_valid && !out_stall)
            begin
                if (due_outputs.size() == 0)
                    report_mismatch("unexpected result", compare_value, '0);
                else
                begin
                    want = due_outputs.pop_front();
                    if (pin_level !== want.pin)
                        report_mismatch("pin_level", VAL_W'(pin_level), VAL_W'(want.pin));
                    if (current_angle !== want.angle)
                        report_mismatch("current_angle", current_angle, want.angle);
                    if (compare_value !== want.compare)
                        report_mismatch("compare_value", compare_value, want.compare);
                    if (output_enabled !== want.enabled)
                        report_mismatch("output_enabled", VAL_W'(output_enabled),
                                        VAL_W'(want.enabled));
                end
            end

            if (in_valid && !in_stall)
                due_outputs.push_back(advance_servo(opcode, angle_value));

            outstanding <= due_outputs.size();
        end
    end

endmodule

`default_nettype wire

// ===== verif/tb_servo_angle_pwm_generator.sv =====
// testbench top of the servo pwm generator: stimulus, settings phases and verdict
`default_nettype none

module tb_servo_angle_pwm_generator;
    import servo_pwm_pkg::*;

    // opcode that the block must ignore
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // settle time for the final drain, sized to a set-angle item in the converter
    localparam int SET_LATENCY = 100;
    // watchdog limit on the whole run, allowing for long gaps on both sides
    localparam int CYCLE_LIMIT = 900000;

    typedef struct packed {
        logic [VAL_W-1:0] min_angle;
        logic [VAL_W-1:0] max_angle;
        logic [VAL_W-1:0] min_pulse;
        logic [VAL_W-1:0] max_pulse;
        logic [VAL_W-1:0] per_us;
        logic [VAL_W-1:0] per_top;
    } servo_settings_t;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 cfg_we      = 1'b0;
    logic [REG_IDX_W-1:0] cfg_index   = '0;
    logic [VAL_W-1:0]     cfg_data    = '0;
    logic                 in_valid    = 1'b0;
    logic [1:0]           opcode      = OP_TICK;
    logic [VAL_W-1:0]     angle_value = '0;
    logic                 out_stall   = 1'b0;
    // calm phases: no gaps and no stalls
    logic                 calm        = 1'b0;

    wire logic             in_stall;
    wire logic             out_valid;
    wire logic             pin_level;
    wire logic [VAL_W-1:0] current_angle;
    wire logic [VAL_W-1:0] compare_value;
    wire logic             output_enabled;

    int fail_count;
    int outstanding;
    int cycles = 0;

    // settings the block holds now, used to aim the angles
    servo_settings_t cur;

    always #6 clk = ~clk;

    servo_angle_pwm_generator u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .angle_value    (angle_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .pin_level      (pin_level),
        .current_angle  (current_angle),
        .compare_value  (compare_value),
        .output_enabled (output_enabled)
    );

    servo_pwm_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .angle_value    (angle_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .pin_level      (pin_level),
        .current_angle  (current_angle),
        .compare_value  (compare_value),
        .output_enabled (output_enabled),
        .fail_count     (fail_count),
        .outstanding    (outstanding)
    );

    // result side back-pressure: runs of free and stalled cycles,
    // mostly short stalls, now and then a long one
    always @(posedge clk or negedge rst_n)
    begin : stall_gen
        int stall_run;
        int pick;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_run = 0;
        end
        else if (calm)
        begin
            out_stall <= 1'b0;
            stall_run = 0;
        end
        else if (stall_run == 0)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                out_stall <= 1'b0;
                stall_run = $urandom_range(1, 30);
            end
            else if (pick < 92)
            begin
                out_stall <= 1'b1;
                stall_run = $urandom_range(1, 3);
            end
            else
            begin
                out_stall <= 1'b1;
                stall_run = $urandom_range(10, 40);
            end
        end
        else
            stall_run = stall_run - 1;
    end

    // watchdog on the whole run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // idle cycles after an item: mostly none or a few, rarely a long pause
    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(99);
        if (calm || pick < 55)
            return 0;
        else if (pick < 88)
            return $urandom_range(1, 3);
        else if (pick < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // angle for a set item: mostly inside the range, then its edges,
    // the field extremes and any value at all
    function automatic logic [VAL_W-1:0] pick_angle();
        int lo, hi, swap, pick;
        lo = $signed(cur.min_angle);
        hi = $signed(cur.max_angle);
        if (lo > hi)
        begin
            swap = lo;
            lo   = hi;
            hi   = swap;
        end
        pick = $urandom_range(99);
        if (pick < 55)
            return VAL_W'(lo + $urandom_range(hi - lo));
        else if (pick < 75)
        begin
            case ($urandom_range(3))
                0:       return VAL_W'(lo - 1);
                1:       return VAL_W'(lo);
                2:       return VAL_W'(hi);
                default: return VAL_W'(hi + 1);
            endcase
        end
        else if (pick < 85)
            return $urandom_range(1) ? 16'h7FFF : 16'h8000;
        else
            return VAL_W'($urandom);
    endfunction

    // settings that mostly keep the period short so the pin toggles often
    function automatic servo_settings_t random_settings();
        servo_settings_t s;
        int lo, span, pulse_cap;
        if ($urandom_range(7) == 0)
            return servo_settings_t'({$urandom, $urandom, $urandom});
        lo   = $urandom_range(400) - 200;
        span = $urandom_range(360);
        s.min_angle = VAL_W'(lo);
        // an inverted range now and then
        s.max_angle = VAL_W'(($urandom_range(9) == 0) ? lo - span : lo + span);
        s.per_us    = ($urandom_range(19) == 0) ? '0 : VAL_W'($urandom_range(20, 2000));
        pulse_cap   = (s.per_us == 0) ? 1000 : int'(s.per_us);
        s.min_pulse = VAL_W'($urandom_range(pulse_cap));
        s.max_pulse = VAL_W'($urandom_range(pulse_cap));
        s.per_top   = ($urandom_range(9) == 0) ? VAL_W'($urandom)
                                               : VAL_W'($urandom_range(2, 60));
        return s;
    endfunction

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // all six registers back to back, only while nothing is in flight
    task automatic apply_settings(input servo_settings_t s);
        write_reg(REG_MIN_ANGLE,    s.min_angle);
        write_reg(REG_MAX_ANGLE,    s.max_angle);
        write_reg(REG_MIN_PULSE_US, s.min_pulse);
        write_reg(REG_MAX_PULSE_US, s.max_pulse);
        write_reg(REG_PERIOD_US,    s.per_us);
        write_reg(REG_PERIOD_TOP,   s.per_top);
        cfg_we <= 1'b0;
        cur = s;
    endtask

    // present one item and hold it until taken; valid only drops when a gap follows
    task automatic send_item(input logic [1:0] op, input logic [VAL_W-1:0] ang);
        int gap;
        in_valid    <= 1'b1;
        opcode      <= op;
        angle_value <= ang;
        do
            @(posedge clk);
        while (in_stall);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid    <= 1'b0;
            opcode      <= 2'($urandom);
            angle_value <= VAL_W'($urandom);
            repeat (gap) @(posedge clk);
        end
    endtask

    // mostly ticks, so periods run through; the rest set, detach and the unused opcode
    task automatic run_random(input int count);
        int pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                send_item(OP_TICK, VAL_W'($urandom));
            else if (pick < 86)
                send_item(OP_SET, pick_angle());
            else if (pick < 94)
                send_item(OP_DETACH, VAL_W'($urandom));
            else
                send_item(OP_UNUSED, VAL_W'($urandom));
        end
    endtask

    // stop sending and wait for every result still owed
    task automatic drain_results(input int settle);
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    initial
    begin
        cur = '{MIN_ANGLE_RST, MAX_ANGLE_RST, MIN_PULSE_US_RST, MAX_PULSE_US_RST,
                PERIOD_US_RST, PERIOD_TOP_RST};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset settings: ignored opcode, detach while already off,
        // clamping at both field extremes, in-range angle, ticks while enabled
        send_item(OP_TICK, 16'h0000);
        send_item(OP_UNUSED, 16'h7FFF);
        send_item(OP_DETACH, 16'hFFFF);
        send_item(OP_TICK, 16'h8000);
        send_item(OP_SET, 16'h8000);
        send_item(OP_SET, 16'h7FFF);
        send_item(OP_SET, 16'd90);
        send_item(OP_SET, 16'd181);
        send_item(OP_TICK, 16'hFFFF);
        send_item(OP_UNUSED, 16'h0000);
        send_item(OP_DETACH, 16'h5555);
        send_item(OP_TICK, 16'hAAAA);
        drain_results(4);

        // fixed settings, each followed by random items
        // short period, compare well inside it
        apply_settings('{16'd0, 16'd180, 16'd10, 16'd90, 16'd100, 16'd12});
        run_random(40);
        drain_results(4);
        // compare equals top: both matches on one tick, pin ends high
        apply_settings('{16'd0, 16'd10, 16'd100, 16'd100, 16'd100, 16'd12});
        run_random(40);
        drain_results(4);
        // equal angle range gives the minimum pulse
        apply_settings('{16'd5, 16'd5, 16'd30, 16'd900, 16'd1, 16'd7});
        run_random(40);
        drain_results(4);
        // inverted angle range
        apply_settings('{16'd100, 16'hFF9C, 16'd544, 16'd2400, 16'd20000, 16'd64615});
        run_random(40);
        drain_results(4);
        // zero period length: every set turns the output off
        apply_settings('{16'd0, 16'd180, 16'd544, 16'd2400, 16'd0, 16'd50});
        run_random(40);
        drain_results(4);
        // full ranges with a one-microsecond period: compare wraps at 16 bits
        apply_settings('{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'd1, 16'hFFFF});
        run_random(40);
        drain_results(4);
        // full ranges, period length and period top at their maximum
        apply_settings('{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        calm <= 1'b1;
        run_random(40);
        drain_results(4);
        calm <= 1'b0;
        // inverted extremes, top of one: the counter is far beyond top here
        apply_settings('{16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000, 16'd1, 16'd1});
        run_random(40);
        drain_results(4);
        // tiny period around zero degrees
        apply_settings('{16'hFFF6, 16'd10, 16'd0, 16'd3, 16'd3, 16'd2});
        run_random(40);
        drain_results(4);

        // random settings; every third phase without gaps or stalls
        for (int phase = 0; phase < 10; phase++)
        begin
            apply_settings(random_settings());
            calm <= (phase % 3 == 2);
            run_random(80);
            drain_results(4);
        end

        // nothing owed now; give the block time to show a stray result
        calm <= 1'b0;
        drain_results(SET_LATENCY);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl/core
rtl/core/servo_pwm_pkg.sv
rtl/core/servo_angle_pwm_generator.sv
rtl/core/servo_pwm_chk.sv
verif/servo_pwm_checker.sv
verif/tb_servo_angle_pwm_generator.sv
